@@ rtl/core/tcp_option_field_extractor_defines.svh @@
// Assertion macros used by the RTL scan stage (tofe_scan).
`ifndef TCP_OPTION_FIELD_EXTRACTOR_DEFINES_SVH
`define TCP_OPTION_FIELD_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define TOFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tofe: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define TOFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tofe: next-cycle check failed");

`else

`define TOFE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TOFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/tofe_pkg.sv @@
package tofe_pkg;

    typedef struct packed {
        logic [7:0] opt_byte;
        logic [5:0] area_len;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [63:0] option_word;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_KIND  = 3'd1,
        PH_SIZE  = 3'd2,
        PH_SKIP  = 3'd3,
        PH_CAPT  = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    // scan stage -> result register
    typedef struct packed {
        logic      emit;
        out_item_t item;
    } res_push_t;

    localparam logic [5:0] MAX_AREA          = 6'd40;
    localparam logic [7:0] KIND_EOL          = 8'd0;
    localparam logic [7:0] KIND_NOP          = 8'd1;
    localparam logic [7:0] MIN_SIZE          = 8'd2;
    localparam logic [7:0] CAPTURE_BYTES     = 8'd8;
    localparam int         CAPTURE_LANES     = 8;
    localparam logic [2:0] FIRST_CAPT_INDEX  = 3'd2;
    localparam logic [2:0] LAST_CAPT_INDEX   = 3'd7;
    localparam logic [7:0] WANTED_KIND_RESET = 8'd254;

endpackage

@@ rtl/core/tofe_in_stage.sv @@
module tofe_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  tofe_pkg::in_item_t byte_data,
    input  logic               consume,
    output logic               held_valid,
    output tofe_pkg::in_item_t held_item
);

    logic               valid_reg;
    logic               valid_next;
    tofe_pkg::in_item_t item_reg;
    logic               load;

    assign byte_stall = valid_reg && !consume;
    assign load       = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= byte_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

@@ rtl/core/tofe_scan.sv @@
`include "tcp_option_field_extractor_defines.svh"

module tofe_scan
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    input  logic                held_valid,
    input  tofe_pkg::in_item_t  held_item,
    input  logic                res_room,
    output logic                consume,
    output tofe_pkg::res_push_t push
);

    logic [7:0]       wanted_kind_reg;
    tofe_pkg::phase_t phase_reg;
    tofe_pkg::phase_t phase_next;
    logic [5:0]       bytes_left_reg;
    logic [5:0]       bytes_left_next;
    logic [5:0]       skip_count_reg;
    logic [5:0]       skip_count_next;
    logic [2:0]       capture_index_reg;
    logic [2:0]       capture_index_next;
    logic [63:0]      capture_word_reg;
    logic [63:0]      capture_word_next;
    logic             match_flag_reg;
    logic             match_flag_next;

    assign consume = held_valid && (!held_item.last || res_room);

    always_comb
    begin
        tofe_pkg::phase_t ph;
        logic [5:0]       bl;
        logic [5:0]       prior_left;
        logic [5:0]       skip;
        logic [2:0]       idx;
        logic [63:0]      word;
        logic             match;
        logic [7:0]       b;
        logic [7:0]       kind;

        b     = held_item.opt_byte;
        ph    = phase_reg;
        bl    = bytes_left_reg;
        skip  = skip_count_reg;
        idx   = capture_index_reg;
        word  = capture_word_reg;
        match = match_flag_reg;

        // first item of a segment: fresh scan state
        if (phase_reg == tofe_pkg::PH_FIRST)
        begin
            ph    = tofe_pkg::PH_KIND;
            bl    = (held_item.area_len > tofe_pkg::MAX_AREA) ? tofe_pkg::MAX_AREA
                                                              : held_item.area_len;
            skip  = 6'd0;
            idx   = 3'd0;
            word  = 64'd0;
            match = 1'b0;
        end

        prior_left = bl;
        kind       = word[7:0];

        if ((bl != 6'd0) && (ph != tofe_pkg::PH_DONE) && (ph != tofe_pkg::PH_FIRST))
        begin
            bl = bl - 6'd1;
            case (ph)
                tofe_pkg::PH_KIND:
                begin
                    if (b == tofe_pkg::KIND_EOL)
                    begin
                        ph = tofe_pkg::PH_DONE;
                    end
                    else if (b != tofe_pkg::KIND_NOP)
                    begin
                        word = {56'd0, b};
                        ph   = (bl == 6'd0) ? tofe_pkg::PH_DONE : tofe_pkg::PH_SIZE;
                    end
                end
                tofe_pkg::PH_SIZE:
                begin
                    // size counts kind and size bytes; prior_left + 1 is what is left
                    if ((b < tofe_pkg::MIN_SIZE) || (b > ({2'b00, prior_left} + 8'd1)))
                    begin
                        ph = tofe_pkg::PH_DONE;
                    end
                    else if ((kind == wanted_kind_reg) && (b == tofe_pkg::CAPTURE_BYTES))
                    begin
                        word = {48'd0, b, kind};
                        idx  = tofe_pkg::FIRST_CAPT_INDEX;
                        ph   = tofe_pkg::PH_CAPT;
                    end
                    else
                    begin
                        skip = 6'(b - tofe_pkg::MIN_SIZE);
                        ph   = (skip == 6'd0) ? tofe_pkg::PH_KIND : tofe_pkg::PH_SKIP;
                    end
                end
                tofe_pkg::PH_SKIP:
                begin
                    skip = skip - 6'd1;
                    if (skip == 6'd0)
                    begin
                        ph = tofe_pkg::PH_KIND;
                    end
                end
                tofe_pkg::PH_CAPT:
                begin
                    for (int lane = 0; lane < tofe_pkg::CAPTURE_LANES; lane++)
                    begin
                        if (idx == 3'(lane))
                        begin
                            word[lane*8 +: 8] = word[lane*8 +: 8] | b;
                        end
                    end
                    if (idx >= tofe_pkg::LAST_CAPT_INDEX)
                    begin
                        match = 1'b1;
                        ph    = tofe_pkg::PH_DONE;
                    end
                    else
                    begin
                        idx = idx + 3'd1;
                    end
                end
                default:
                begin
                    ph = tofe_pkg::PH_DONE;
                end
            endcase
        end

        push.emit             = consume && held_item.last;
        push.item.found       = match;
        push.item.option_word = match ? word : 64'd0;

        if (held_item.last)
        begin
            phase_next         = tofe_pkg::PH_FIRST;
            bytes_left_next    = 6'd0;
            skip_count_next    = 6'd0;
            capture_index_next = 3'd0;
            capture_word_next  = 64'd0;
            match_flag_next    = 1'b0;
        end
        else
        begin
            phase_next         = ph;
            bytes_left_next    = bl;
            skip_count_next    = skip;
            capture_index_next = idx;
            capture_word_next  = word;
            match_flag_next    = match;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_kind_reg <= tofe_pkg::WANTED_KIND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            wanted_kind_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= tofe_pkg::PH_FIRST;
            bytes_left_reg    <= 6'd0;
            skip_count_reg    <= 6'd0;
            capture_index_reg <= 3'd0;
            capture_word_reg  <= 64'd0;
            match_flag_reg    <= 1'b0;
        end
        else if (consume)
        begin
            phase_reg         <= phase_next;
            bytes_left_reg    <= bytes_left_next;
            skip_count_reg    <= skip_count_next;
            capture_index_reg <= capture_index_next;
            capture_word_reg  <= capture_word_next;
            match_flag_reg    <= match_flag_next;
        end
    end

    `TOFE_ASSERT_NOW(a_left_capped, clk, rst_n, 1'b1, bytes_left_reg <= tofe_pkg::MAX_AREA)
    `TOFE_ASSERT_NOW(a_match_done, clk, rst_n, match_flag_reg,
                     phase_reg == tofe_pkg::PH_DONE)
    `TOFE_ASSERT_NOW(a_capt_index, clk, rst_n, phase_reg == tofe_pkg::PH_CAPT,
                     capture_index_reg >= tofe_pkg::FIRST_CAPT_INDEX)
    `TOFE_ASSERT_NEXT(a_last_rearms, clk, rst_n, consume && held_item.last,
                      phase_reg == tofe_pkg::PH_FIRST && !match_flag_reg)

endmodule

@@ rtl/core/tofe_out_stage.sv @@
module tofe_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  tofe_pkg::res_push_t push,
    output logic                res_room,
    output logic                result_valid,
    input  logic                result_stall,
    output tofe_pkg::out_item_t result_data
);

    logic                valid_reg;
    logic                valid_next;
    tofe_pkg::out_item_t item_reg;

    assign res_room = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (push.emit)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.emit)
        begin
            item_reg <= push.item;
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = item_reg;

endmodule

@@ rtl/core/tcp_option_field_extractor.sv @@
// Channel      Dir   Handshake        Payload
// byte_*       in    valid / stall    tofe_pkg::in_item_t  (one option byte)
// result_*     out   valid / stall    tofe_pkg::out_item_t (found, option_word)
// cfg_*        in    valid / ready    wanted_kind, 8 bits
//
// One byte is taken every cycle while byte_stall is low; a byte passes the input register, then the result register.
// The scan state updates in one pass between the input and result registers.
// rst_n is asynchronous: scan state clears, wanted_kind returns to 254.
// A stalled result only holds up the input when the next held byte ends a segment.
// cfg_ready is always high; write only while the block is idle.
module tcp_option_field_extractor
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  tofe_pkg::in_item_t  byte_data,
    output logic                result_valid,
    input  logic                result_stall,
    output tofe_pkg::out_item_t result_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    logic                held_valid;
    tofe_pkg::in_item_t  held_item;
    logic                consume;
    logic                res_room;
    tofe_pkg::res_push_t push;

    assign cfg_ready = 1'b1;

    tofe_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .consume    (consume),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    tofe_scan u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .held_valid (held_valid),
        .held_item  (held_item),
        .res_room   (res_room),
        .consume    (consume),
        .push       (push)
    );

    tofe_out_stage u_out_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .res_room     (res_room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

@@ dv/tb_tcp_option_field_extractor.sv @@
`timescale 1ns / 1ps

module tb_tcp_option_field_extractor;

    typedef logic [7:0] byte_q_t[$];

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 byte_valid = 1'b0;
    logic                 byte_stall;
    tofe_pkg::in_item_t   byte_data = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    tofe_pkg::out_item_t  result_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [7:0]           cfg_data = '0;

    tcp_option_field_extractor DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    tofe_pkg::in_item_t   option_bytes_to_send[$];
    tofe_pkg::out_item_t  expected_option_results[$];
    int                   error_count = 0;
    int                   send_gap_pct = 30;
    int                   recv_stall_pct = 30;
    int                   send_gap = 0;
    int                   stall_left = 0;
    int                   stall_pick;
    tofe_pkg::out_item_t  want;

    // scanner model state
    logic [7:0]        kind_cfg = tofe_pkg::WANTED_KIND_RESET;
    tofe_pkg::phase_t  scan_ph = tofe_pkg::PH_FIRST;
    logic [5:0]        remain = '0;
    logic [5:0]        skip_left = '0;
    logic [2:0]        cap_idx = '0;
    logic [63:0]       cap_word = '0;
    logic              matched = 1'b0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    function automatic int gap_len(input int pct);
        int r;
        if ($urandom_range(0, 99) >= pct)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic clear_scan();
        scan_ph   = tofe_pkg::PH_FIRST;
        remain    = '0;
        skip_left = '0;
        cap_idx   = '0;
        cap_word  = '0;
        matched   = 1'b0;
    endtask

    task automatic scan_option_byte(input tofe_pkg::in_item_t it);
        logic [5:0]          prior;
        logic [7:0]          b;
        tofe_pkg::out_item_t res;
        b = it.opt_byte;
        if (scan_ph == tofe_pkg::PH_FIRST)
        begin
            clear_scan();
            remain  = (it.area_len > tofe_pkg::MAX_AREA) ? tofe_pkg::MAX_AREA : it.area_len;
            scan_ph = tofe_pkg::PH_KIND;
        end
        if (remain != 0 && scan_ph != tofe_pkg::PH_DONE)
        begin
            prior  = remain;
            remain = remain - 6'd1;
            case (scan_ph)
                tofe_pkg::PH_KIND:
                begin
                    if (b == tofe_pkg::KIND_EOL)
                        scan_ph = tofe_pkg::PH_DONE;
                    else if (b != tofe_pkg::KIND_NOP)
                    begin
                        cap_word = {56'd0, b};
                        scan_ph  = (remain == 0) ? tofe_pkg::PH_DONE : tofe_pkg::PH_SIZE;
                    end
                end
                tofe_pkg::PH_SIZE:
                begin
                    if (b < tofe_pkg::MIN_SIZE || int'(b) > int'(prior) + 1)
                        scan_ph = tofe_pkg::PH_DONE;
                    else if (cap_word[7:0] == kind_cfg && b == tofe_pkg::CAPTURE_BYTES)
                    begin
                        cap_word = {48'd0, b, cap_word[7:0]};
                        cap_idx  = tofe_pkg::FIRST_CAPT_INDEX;
                        scan_ph  = tofe_pkg::PH_CAPT;
                    end
                    else
                    begin
                        skip_left = 6'(b - tofe_pkg::MIN_SIZE);
                        scan_ph   = (skip_left == 0) ? tofe_pkg::PH_KIND : tofe_pkg::PH_SKIP;
                    end
                end
                tofe_pkg::PH_SKIP:
                begin
                    skip_left = skip_left - 6'd1;
                    if (skip_left == 0)
                        scan_ph = tofe_pkg::PH_KIND;
                end
                tofe_pkg::PH_CAPT:
                begin
                    cap_word[8 * cap_idx +: 8] = b;
                    if (cap_idx >= tofe_pkg::LAST_CAPT_INDEX)
                    begin
                        matched = 1'b1;
                        scan_ph = tofe_pkg::PH_DONE;
                    end
                    else
                        cap_idx = cap_idx + 3'd1;
                end
                default:
                    scan_ph = tofe_pkg::PH_DONE;
            endcase
        end
        if (it.last)
        begin
            res.found       = matched;
            res.option_word = matched ? cap_word : 64'd0;
            expected_option_results.push_back(res);
            clear_scan();
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data  <= '0;
            send_gap   <= 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                scan_option_byte(byte_data);
            if (!(byte_valid && byte_stall))
            begin
                if (send_gap > 0)
                begin
                    byte_valid <= 1'b0;
                    send_gap   <= send_gap - 1;
                end
                else if (option_bytes_to_send.size() != 0)
                begin
                    byte_valid <= 1'b1;
                    byte_data  <= option_bytes_to_send.pop_front();
                    send_gap   <= gap_len(send_gap_pct);
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_option_results.size() == 0)
                begin
                    $error("result transfer with none expected");
                    error_count++;
                end
                else
                begin
                    want = expected_option_results.pop_front();
                    if (result_data.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, result_data.found);
                        error_count++;
                    end
                    if (result_data.option_word !== want.option_word)
                    begin
                        $error("option_word: expected %h, got %h",
                               want.option_word, result_data.option_word);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left   <= stall_left - 1;
            end
            else
            begin
                stall_pick = gap_len(recv_stall_pct);
                result_stall <= (stall_pick > 0);
                stall_left   <= (stall_pick > 0) ? stall_pick - 1 : 0;
            end
        end
    end

    task automatic write_kind(input logic [7:0] k);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        kind_cfg = k;
        cfg_valid <= 1'b0;
    endtask

    task automatic push_segment(input byte_q_t bytes, input logic [5:0] alen);
        tofe_pkg::in_item_t it;
        foreach (bytes[i])
        begin
            it.opt_byte = bytes[i];
            it.area_len = (i == 0) ? alen : 6'($urandom_range(0, 63));
            it.last     = (i == bytes.size() - 1);
            option_bytes_to_send.push_back(it);
        end
    endtask

    task automatic add_random_segment(output int scanned);
        byte_q_t area;
        int      alen;
        int      eff;
        int      room;
        int      sz;
        int      nitems;
        int      r;
        r = $urandom_range(0, 99);
        if (r < 6)
            alen = $urandom_range(41, 63);
        else if (r < 16)
            alen = 40;
        else
            alen = $urandom_range(0, 40);
        eff = (alen > 40) ? 40 : alen;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat (eff) area.push_back(8'($urandom));
        end
        else
        begin
            while (area.size() < eff)
            begin
                room = eff - area.size();
                r = $urandom_range(0, 99);
                if (r < 15)
                    area.push_back(tofe_pkg::KIND_NOP);
                else if (r < 50 && room >= 8)
                begin
                    area.push_back(kind_cfg);
                    area.push_back(tofe_pkg::CAPTURE_BYTES);
                    repeat (6) area.push_back(8'($urandom));
                end
                else if (r < 54)
                begin
                    area.push_back(tofe_pkg::KIND_EOL);
                    repeat (room - 1) area.push_back(8'($urandom));
                end
                else if (r < 60)
                begin
                    // malformed size
                    area.push_back(8'($urandom_range(2, 255)));
                    area.push_back(8'($urandom));
                end
                else
                begin
                    area.push_back((r < 66) ? kind_cfg : 8'($urandom_range(2, 255)));
                    if (room >= 2)
                    begin
                        sz = $urandom_range(2, (room < 12) ? room : 12);
                        area.push_back(8'(sz));
                        repeat (sz - 2) area.push_back(8'($urandom));
                    end
                end
            end
        end
        r = $urandom_range(0, 9);
        if (eff == 0)
            nitems = $urandom_range(1, 4);
        else if (r == 0)
            nitems = $urandom_range(1, eff);
        else if (r == 1)
            nitems = eff + $urandom_range(1, 4);
        else
            nitems = eff;
        while (area.size() < nitems)
            area.push_back(8'($urandom));
        while (area.size() > nitems)
            void'(area.pop_back());
        push_segment(area, 6'(alen));
        scanned = (nitems < eff) ? nitems : eff;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (option_bytes_to_send.size() != 0 || byte_valid
               || expected_option_results.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    initial
    begin
        byte_q_t     seg;
        logic [7:0]  phase_kinds [8];
        int          scanned_total;
        int          n;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_kind(tofe_pkg::WANTED_KIND_RESET);
        @(negedge clk);
        seg = '{8'hFE, 8'h08, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55};
        push_segment(seg, 6'd8);
        seg = '{8'hFF};
        push_segment(seg, 6'd0);
        // single-transfer segment, saturated length
        seg = '{tofe_pkg::KIND_NOP};
        push_segment(seg, 6'd63);
        // size byte missing
        seg = '{tofe_pkg::KIND_NOP, tofe_pkg::KIND_NOP, 8'h05};
        push_segment(seg, 6'd3);
        seg = '{8'h07, 8'h01};
        push_segment(seg, 6'd2);
        // size larger than what is left
        seg = '{8'h09, 8'h05};
        push_segment(seg, 6'd4);
        seg = '{tofe_pkg::KIND_EOL, 8'hFE, 8'h08};
        push_segment(seg, 6'd3);
        // segment ends mid-capture
        seg = '{8'hFE, 8'h08, 8'h01, 8'h02, 8'h03};
        push_segment(seg, 6'd10);
        drain();

        phase_kinds = '{8'd255, 8'd0, 8'd1, 8'd2, 8'd8,
                        8'($urandom), 8'($urandom), tofe_pkg::WANTED_KIND_RESET};
        for (int p = 0; p < 8; p++)
        begin
            write_kind(phase_kinds[p]);
            @(negedge clk);
            send_gap_pct   = (p == 3) ? 0 : $urandom_range(10, 60);
            recv_stall_pct = (p == 3) ? 0 : $urandom_range(10, 60);
            scanned_total = 0;
            while (scanned_total < 100)
            begin
                add_random_segment(n);
                scanned_total += n;
            end
            drain();
        end

        if (error_count == 0 && expected_option_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
